// File: hdl/thp_sensor_compensation_unit_defines.svh
// Assertion macros for the sensor compensation unit
`ifndef THP_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define THP_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// check that cond holds whenever trig holds
`define THP_ASSERT_IMPL(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("thp check failed");

// check that cond holds in the cycle after trig
`define THP_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("thp check failed");

`endif

// File: hdl/thp_pkg.sv
// Shared types, constants and helpers of the sensor compensation unit
package thp_pkg;

    localparam int DIV_STAGES = 32;

    typedef enum logic [2:0] {
        REG_TEMP_COEFFS  = 3'd0,
        REG_PRESS_A      = 3'd1,
        REG_PRESS_B      = 3'd2,
        REG_PRESS_C      = 3'd3,
        REG_HUM_COEFFS   = 3'd4,
        REG_TEMP_LIMITS  = 3'd5,
        REG_PRESS_LIMITS = 3'd6,
        REG_HUM_LIMITS   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [19:0]        pressure;
        logic [16:0]        humidity;
        logic               temp_alarm;
        logic               press_alarm;
        logic               hum_alarm;
    } out_word_t;

    typedef struct packed {
        logic [15:0] temperature;
        logic        temp_alarm;
        logic [16:0] humidity;
        logic        hum_alarm;
        logic        dbl;
        logic        zero;
    } side_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

// File: hdl/thp_div.sv
// Pipelined 32-bit restoring divider, one quotient bit per stage, with sideband
module thp_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   dividend,
    input  logic [31:0]   divisor,
    input  thp_pkg::side_t in_side,
    output logic          out_valid,
    output logic [31:0]   quotient,
    output thp_pkg::side_t out_side
);
    import thp_pkg::*;

    logic [31:0] rem_reg [DIV_STAGES];
    logic [31:0] num_reg [DIV_STAGES];
    logic [31:0] den_reg [DIV_STAGES];
    side_t       side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    logic [31:0] rem_next [DIV_STAGES];
    logic [31:0] num_next [DIV_STAGES];
    logic [31:0] den_src  [DIV_STAGES];
    side_t       side_src [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_src;

    always_comb
    begin
        logic [31:0] r;
        logic [31:0] n;
        logic [32:0] trial;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                r           = '0;
                n           = dividend;
                den_src[k]  = divisor;
                side_src[k] = in_side;
                vld_src[k]  = in_valid;
            end
            else
            begin
                r           = rem_reg[k-1];
                n           = num_reg[k-1];
                den_src[k]  = den_reg[k-1];
                side_src[k] = side_reg[k-1];
                vld_src[k]  = vld_reg[k-1];
            end
            trial = {r, n[31]} - {1'b0, den_src[k]};
            if (!trial[32])
            begin
                rem_next[k] = trial[31:0];
                num_next[k] = {n[30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = {r[30:0], n[31]};
                num_next[k] = {n[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= num_next[k];
                den_reg[k]  <= den_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quotient  = num_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// File: hdl/thp_sensor_compensation_unit.sv
// Top level of the temperature, pressure and humidity compensation unit
// Throughput: one word per cycle unless the output stalls; the 32-stage
// divider pipeline sets the depth.
// A stalled output holds every stage in place; nothing is dropped or repeated.
// Reset clears all valid bits and loads coefficients 0 and the default limits.
`include "thp_sensor_compensation_unit_defines.svh"
module thp_sensor_compensation_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  thp_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output thp_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import thp_pkg::*;

    logic [47:0] tc_reg, pa_reg, pb_reg, pc_reg;
    logic [63:0] hc_reg;
    logic [31:0] tl_reg;
    logic [39:0] pl_reg;
    logic [33:0] hl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= '0;
            hc_reg <= '0;
            tl_reg <= 32'd557117536;
            pl_reg <= 40'd115343390000;
            hl_reg <= 34'd13421772800;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_COEFFS:  tc_reg <= cfg_data[47:0];
                REG_PRESS_A:      pa_reg <= cfg_data[47:0];
                REG_PRESS_B:      pb_reg <= cfg_data[47:0];
                REG_PRESS_C:      pc_reg <= cfg_data[47:0];
                REG_HUM_COEFFS:   hc_reg <= cfg_data;
                REG_TEMP_LIMITS:  tl_reg <= cfg_data[31:0];
                REG_PRESS_LIMITS: pl_reg <= cfg_data[39:0];
                REG_HUM_LIMITS:   hl_reg <= cfg_data[33:0];
                default:          tl_reg <= tl_reg;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'b0, tc_reg[15:0]};
    assign t2 = {{16{tc_reg[31]}}, tc_reg[31:16]};
    assign t3 = {{16{tc_reg[47]}}, tc_reg[47:32]};
    assign p1 = {16'b0, pa_reg[15:0]};
    assign p2 = {{16{pa_reg[31]}}, pa_reg[31:16]};
    assign p3 = {{16{pa_reg[47]}}, pa_reg[47:32]};
    assign p4 = {{16{pb_reg[15]}}, pb_reg[15:0]};
    assign p5 = {{16{pb_reg[31]}}, pb_reg[31:16]};
    assign p6 = {{16{pb_reg[47]}}, pb_reg[47:32]};
    assign p7 = {{16{pc_reg[15]}}, pc_reg[15:0]};
    assign p8 = {{16{pc_reg[31]}}, pc_reg[31:16]};
    assign p9 = {{16{pc_reg[47]}}, pc_reg[47:32]};
    assign h1 = {24'b0, hc_reg[7:0]};
    assign h2 = {{16{hc_reg[23]}}, hc_reg[23:8]};
    assign h3 = {24'b0, hc_reg[31:24]};
    assign h4 = {{20{hc_reg[43]}}, hc_reg[43:32]};
    assign h5 = {{20{hc_reg[55]}}, hc_reg[55:44]};
    assign h6 = {{24{hc_reg[63]}}, hc_reg[63:56]};

    logic adv;
    logic [10:0] pv_reg;
    logic q1_vld_reg, q2_vld_reg, out_vld_reg;

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    logic [31:0] a_x1_reg, a_d_reg;
    logic [19:0] a_praw_reg, b_praw_reg, c_praw_reg, d_praw_reg, e_praw_reg;
    logic [19:0] f_praw_reg, g_praw_reg;
    logic [15:0] a_hraw_reg, b_hraw_reg, c_hraw_reg, d_hraw_reg, e_hraw_reg;
    logic [31:0] b_at_reg, b_dd_reg, c_at_reg, c_b1_reg, d_tf_reg;
    logic [15:0] e_temp_reg, f_temp_reg, g_temp_reg, h_temp_reg, i_temp_reg;
    logic [15:0] j_temp_reg, k_temp_reg;
    logic e_talm_reg, f_talm_reg, g_talm_reg, h_talm_reg, i_talm_reg, j_talm_reg, k_talm_reg;
    logic [31:0] e_qq_reg, e_ap5_reg, e_ap2_reg, e_hx5_reg, e_v2_reg, e_v3_reg;
    logic [31:0] f_b6_reg, f_p3_reg, f_v5_reg, f_v4m_reg, f_ap5_reg, f_ap2_reg;
    logic [31:0] g_b_reg, g_a2_reg, g_v2h_reg, g_v5_reg;
    logic [31:0] h_a3m_reg, h_p_reg, h_v2f_reg, h_v5_reg;
    logic [31:0] i_a3_reg, i_p_reg, i_v3_reg;
    logic [31:0] j_v4m_reg, j_v3_reg, j_a3_reg, j_p_reg;
    logic [31:0] k_v4h_reg, k_v3_reg, k_a3_reg, k_p_reg;

    logic [31:0] tv, pa, pq, hx;
    logic signed [31:0] tlo, thi;
    logic [15:0] temp_next;
    logic        talm_next;

    always_comb
    begin
        tv  = asr(d_tf_reg * 32'd5 + 32'd128, 8);
        tlo = {{16{tl_reg[15]}}, tl_reg[15:0]};
        thi = {{16{tl_reg[31]}}, tl_reg[31:16]};
        if ($signed(tv) <= tlo)
        begin
            temp_next = tl_reg[15:0];
            talm_next = 1'b1;
        end
        else if ($signed(tv) >= thi)
        begin
            temp_next = tl_reg[31:16];
            talm_next = 1'b1;
        end
        else
        begin
            temp_next = tv[15:0];
            talm_next = 1'b0;
        end
        pa = asr(d_tf_reg, 1) - 32'd64000;
        pq = asr(pa, 2);
        hx = d_tf_reg - 32'd76800;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (adv)
        begin
            pv_reg <= {pv_reg[9:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x1_reg   <= ({12'b0, in_data.raw_temperature} >> 3) - {15'b0, t1[15:0], 1'b0};
            a_d_reg    <= ({12'b0, in_data.raw_temperature} >> 4) - t1;
            a_praw_reg <= in_data.raw_pressure;
            a_hraw_reg <= in_data.raw_humidity;

            b_at_reg   <= asr(a_x1_reg * t2, 11);
            b_dd_reg   <= a_d_reg * a_d_reg;
            b_praw_reg <= a_praw_reg;
            b_hraw_reg <= a_hraw_reg;

            c_at_reg   <= b_at_reg;
            c_b1_reg   <= asr(b_dd_reg, 12) * t3;
            c_praw_reg <= b_praw_reg;
            c_hraw_reg <= b_hraw_reg;

            d_tf_reg   <= c_at_reg + asr(c_b1_reg, 14);
            d_praw_reg <= c_praw_reg;
            d_hraw_reg <= c_hraw_reg;

            e_temp_reg <= temp_next;
            e_talm_reg <= talm_next;
            e_qq_reg   <= pq * pq;
            e_ap5_reg  <= pa * p5;
            e_ap2_reg  <= p2 * pa;
            e_hx5_reg  <= h5 * hx;
            e_v2_reg   <= hx * h6;
            e_v3_reg   <= hx * h3;
            e_praw_reg <= d_praw_reg;
            e_hraw_reg <= d_hraw_reg;

            f_b6_reg   <= asr(e_qq_reg, 11) * p6;
            f_p3_reg   <= p3 * asr(e_qq_reg, 13);
            f_v5_reg   <= asr({2'b0, e_hraw_reg, 14'b0} - {h4[11:0], 20'b0}
                              - e_hx5_reg + 32'd16384, 15);
            f_v4m_reg  <= asr(e_v2_reg, 10) * (asr(e_v3_reg, 11) + 32'd32768);
            f_ap5_reg  <= e_ap5_reg;
            f_ap2_reg  <= e_ap2_reg;
            f_praw_reg <= e_praw_reg;
            f_temp_reg <= e_temp_reg;
            f_talm_reg <= e_talm_reg;

            g_b_reg    <= asr(f_b6_reg + {f_ap5_reg[30:0], 1'b0}, 2) + {p4[15:0], 16'b0};
            g_a2_reg   <= asr(asr(f_p3_reg, 3) + asr(f_ap2_reg, 1), 18);
            g_v2h_reg  <= (asr(f_v4m_reg, 10) + 32'd2097152) * h2;
            g_v5_reg   <= f_v5_reg;
            g_praw_reg <= f_praw_reg;
            g_temp_reg <= f_temp_reg;
            g_talm_reg <= f_talm_reg;

            h_a3m_reg  <= (32'd32768 + g_a2_reg) * p1;
            h_p_reg    <= (32'd1048576 - {12'b0, g_praw_reg} - asr(g_b_reg, 12)) * 32'd3125;
            h_v2f_reg  <= asr(g_v2h_reg + 32'd8192, 14);
            h_v5_reg   <= g_v5_reg;
            h_temp_reg <= g_temp_reg;
            h_talm_reg <= g_talm_reg;

            i_a3_reg   <= asr(h_a3m_reg, 15);
            i_p_reg    <= h_p_reg;
            i_v3_reg   <= h_v5_reg * h_v2f_reg;
            i_temp_reg <= h_temp_reg;
            i_talm_reg <= h_talm_reg;

            j_v4m_reg  <= asr(i_v3_reg, 15) * asr(i_v3_reg, 15);
            j_v3_reg   <= i_v3_reg;
            j_a3_reg   <= i_a3_reg;
            j_p_reg    <= i_p_reg;
            j_temp_reg <= i_temp_reg;
            j_talm_reg <= i_talm_reg;

            k_v4h_reg  <= asr(j_v4m_reg, 7) * h1;
            k_v3_reg   <= j_v3_reg;
            k_a3_reg   <= j_a3_reg;
            k_p_reg    <= j_p_reg;
            k_temp_reg <= j_temp_reg;
            k_talm_reg <= j_talm_reg;
        end
    end

    logic [31:0] hv;
    logic [16:0] hq, hum_next;
    logic        halm_next;
    side_t       div_side;

    always_comb
    begin
        hv = k_v3_reg - asr(k_v4h_reg, 4);
        if ($signed(hv) < 0)
        begin
            hv = '0;
        end
        if ($signed(hv) > 32'sd419430400)
        begin
            hv = 32'd419430400;
        end
        hq = hv[28:12];
        if (hq <= hl_reg[16:0])
        begin
            hum_next  = hl_reg[16:0];
            halm_next = 1'b1;
        end
        else if (hq >= hl_reg[33:17])
        begin
            hum_next  = hl_reg[33:17];
            halm_next = 1'b1;
        end
        else
        begin
            hum_next  = hq;
            halm_next = 1'b0;
        end
        div_side.temperature = k_temp_reg;
        div_side.temp_alarm  = k_talm_reg;
        div_side.humidity    = hum_next;
        div_side.hum_alarm   = halm_next;
        div_side.dbl         = k_p_reg[31];
        div_side.zero        = (k_a3_reg == 32'd0);
    end

    logic        dv_vld;
    logic [31:0] dv_quo;
    side_t       dv_side;

    thp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pv_reg[10]),
        .dividend  (k_p_reg[31] ? k_p_reg : {k_p_reg[30:0], 1'b0}),
        .divisor   (k_a3_reg),
        .in_side   (div_side),
        .out_valid (dv_vld),
        .quotient  (dv_quo),
        .out_side  (dv_side)
    );

    logic [31:0] pdiv;
    logic [31:0] q1_p_reg, q1_sm_reg, q2_p_reg, q2_a_reg, q2_b_reg;
    side_t       q1_side_reg, q2_side_reg;
    out_word_t   out_reg;

    assign pdiv = dv_side.dbl ? {dv_quo[30:0], 1'b0} : dv_quo;

    logic [31:0] pn;
    logic [19:0] press_next;
    logic        palm_next;

    always_comb
    begin
        pn = q2_p_reg + asr(asr(q2_a_reg, 12) + asr(q2_b_reg, 13) + p7, 4);
        if (q2_side_reg.zero)
        begin
            pn = '0;
        end
        if (pn <= {12'b0, pl_reg[19:0]})
        begin
            press_next = pl_reg[19:0];
            palm_next  = 1'b1;
        end
        else if (pn >= {12'b0, pl_reg[39:20]})
        begin
            press_next = pl_reg[39:20];
            palm_next  = 1'b1;
        end
        else
        begin
            press_next = pn[19:0];
            palm_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg  <= 1'b0;
            q2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            q1_vld_reg  <= dv_vld;
            q2_vld_reg  <= q1_vld_reg;
            out_vld_reg <= q2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_p_reg    <= pdiv;
            q1_sm_reg   <= (pdiv >> 3) * (pdiv >> 3);
            q1_side_reg <= dv_side;

            q2_p_reg    <= q1_p_reg;
            q2_a_reg    <= p9 * (q1_sm_reg >> 13);
            q2_b_reg    <= (q1_p_reg >> 2) * p8;
            q2_side_reg <= q1_side_reg;

            out_reg.temperature <= q2_side_reg.temperature;
            out_reg.temp_alarm  <= q2_side_reg.temp_alarm;
            out_reg.humidity    <= q2_side_reg.humidity;
            out_reg.hum_alarm   <= q2_side_reg.hum_alarm;
            out_reg.pressure    <= press_next;
            out_reg.press_alarm <= palm_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    `THP_ASSERT_IMPL(a_press_alarm_at_limit, out_valid && out_data.press_alarm,
        out_data.pressure == pl_reg[19:0] || out_data.pressure == pl_reg[39:20])
    `THP_ASSERT_IMPL(a_press_pass_inside, out_valid && !out_data.press_alarm,
        out_data.pressure > pl_reg[19:0] && out_data.pressure < pl_reg[39:20])
    `THP_ASSERT_IMPL(a_hum_alarm_at_limit, out_valid && out_data.hum_alarm,
        out_data.humidity == hl_reg[16:0] || out_data.humidity == hl_reg[33:17])
    `THP_ASSERT_NEXT(a_stall_holds_pipe, pv_reg[10] && !adv, pv_reg[10])

endmodule
